>>> rtl/core/pointer_activity_layer_switch_unit_assert.svh
// Assertion macros for the pointer activity layer switch.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef POINTER_ACTIVITY_LAYER_SWITCH_UNIT_ASSERT_SVH
`define POINTER_ACTIVITY_LAYER_SWITCH_UNIT_ASSERT_SVH

// Property checked at every clock edge outside reset.
`define PALSW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next.
`define PALSW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/palsw_pkg.sv
// Shared types and constants for the pointer activity layer switch.
// No dependencies.
package palsw_pkg;

	typedef enum logic [1:0] {
		CMD_KEY       = 2'd0,
		CMD_REPORT    = 2'd1,
		CMD_FORCE_ON  = 2'd2,
		CMD_FORCE_OFF = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		CHG_NONE = 2'd0,
		CHG_ON   = 2'd1,
		CHG_OFF  = 2'd2
	} change_t;

	localparam logic [1:0] KIND_TOGGLE = 2'd1;
	localparam logic [1:0] KIND_GOTO   = 2'd2;

	localparam int unsigned ADDR_W = 5;

	localparam logic [2:0] REG_ENABLE     = 3'd0;
	localparam logic [2:0] REG_LAYER      = 3'd1;
	localparam logic [2:0] REG_IDLE_TMO   = 3'd2;
	localparam logic [2:0] REG_KEY_DELAY  = 3'd3;
	localparam logic [2:0] REG_DEBOUNCE   = 3'd4;
	localparam logic [2:0] REG_MOTION_THR = 3'd5;
	localparam logic [2:0] REG_SUPPRESS   = 3'd6;

	localparam logic [15:0] RST_IDLE_TMO   = 16'd650;
	localparam logic [15:0] RST_KEY_DELAY  = 16'd200;
	localparam logic [7:0]  RST_DEBOUNCE   = 8'd25;
	localparam logic [7:0]  RST_MOTION_THR = 8'd10;

	typedef struct packed {
		logic        enable;
		logic [4:0]  ptr_layer;
		logic [15:0] idle_timeout;
		logic [15:0] key_guard;
		logic [7:0]  hold_debounce;
		logic [7:0]  motion_threshold;
		logic        suppress_in_delay;
	} cfg_t;

	typedef struct packed {
		cmd_t               command;
		logic [15:0]        now_ms;
		logic               key_is_event;
		logic               key_pressed;
		logic [1:0]         key_kind;
		logic [4:0]         key_target_layer;
		logic signed [7:0]  move_x;
		logic signed [7:0]  move_y;
		logic signed [7:0]  scroll_h;
		logic signed [7:0]  scroll_v;
		logic [7:0]         buttons;
	} item_t;

	typedef struct packed {
		logic        layer_active;
		logic [15:0] activity_time;
		logic [15:0] last_key_time;
		logic [7:0]  held_keys;
	} state_t;

	typedef struct packed {
		logic    layer_engaged;
		change_t layer_change;
		logic    zero_report;
	} result_t;

	// |a| + |b| of two 8-bit two's complement values, clipped at 255
	function automatic logic [7:0] sat_mag_sum(logic [7:0] a, logic [7:0] b);
		logic [8:0] ma;
		logic [8:0] mb;
		logic [9:0] s;
		ma = a[7] ? (9'd256 - {1'b0, a}) : {1'b0, a};
		mb = b[7] ? (9'd256 - {1'b0, b}) : {1'b0, b};
		s  = {1'b0, ma} + {1'b0, mb};
		return (s > 10'd255) ? 8'hFF : s[7:0];
	endfunction

endpackage

>>> rtl/core/palsw_next.sv
// Next-state and result logic for one beat of the layer switch.
// Depends on palsw_pkg.
module palsw_next (
	input  palsw_pkg::cfg_t    cfg,
	input  palsw_pkg::state_t  cur,
	input  palsw_pkg::item_t   item,
	output palsw_pkg::state_t  nxt,
	output palsw_pkg::result_t res
);
	import palsw_pkg::*;

	logic [7:0]  motion;
	logic [7:0]  scroll;
	logic        button;
	logic        moving_on;
	logic        moving_act;
	logic [15:0] since_key;
	logic [15:0] idle;
	logic        do_exit;
	logic [7:0]  held_upd;
	change_t     change;
	logic        erase;

	assign motion    = sat_mag_sum(item.move_x, item.move_y);
	assign scroll    = sat_mag_sum(item.scroll_h, item.scroll_v);
	assign button    = |item.buttons;
	// activation wants scroll above a quarter of the threshold; while on any scroll counts
	assign moving_on  = (motion > cfg.motion_threshold) || (scroll > {2'b00, cfg.motion_threshold[7:2]})
		|| button;
	assign moving_act = (motion > cfg.motion_threshold) || (scroll != 8'd0) || button;
	assign since_key = item.now_ms - cur.last_key_time;
	assign idle      = item.now_ms - cur.activity_time;

	always_comb begin
		held_upd = cur.held_keys;
		if (item.key_is_event) begin
			if (item.key_pressed) begin
				if (cur.held_keys != 8'hFF) held_upd = cur.held_keys + 8'd1;
			end else begin
				if (cur.held_keys != 8'd0) held_upd = cur.held_keys - 8'd1;
			end
		end
	end

	assign do_exit = (item.key_target_layer != cfg.ptr_layer) &&
		((item.key_kind == KIND_TOGGLE) || ((item.key_kind == KIND_GOTO) && item.key_pressed));

	always_comb begin
		nxt    = cur;
		change = CHG_NONE;
		erase  = 1'b0;
		if (cfg.enable) begin
			unique case (item.command)
				CMD_KEY: begin
					if (!cur.layer_active && item.key_is_event) begin
						nxt.last_key_time = item.now_ms;
					end else if (do_exit) begin
						nxt.activity_time = '0;
						nxt.held_keys     = '0;
						nxt.layer_active  = 1'b0;
						if (cur.layer_active) change = CHG_OFF;
					end else begin
						nxt.held_keys     = held_upd;
						nxt.activity_time = item.now_ms;
					end
				end
				CMD_REPORT: begin
					if (!cur.layer_active) begin
						if (since_key <= cfg.key_guard) begin
							erase = cfg.suppress_in_delay;
						end else if (moving_on) begin
							nxt.activity_time = item.now_ms;
							nxt.layer_active  = 1'b1;
							change            = CHG_ON;
						end
					end else if (moving_act) begin
						nxt.activity_time = item.now_ms;
					end else if ((idle > {8'd0, cfg.hold_debounce}) && (cur.held_keys == 8'd0)
						&& (idle > cfg.idle_timeout)) begin
						nxt.activity_time = '0;
						nxt.layer_active  = 1'b0;
						change            = CHG_OFF;
					end
				end
				CMD_FORCE_ON: begin
					nxt.activity_time = item.now_ms;
					nxt.layer_active  = 1'b1;
					if (!cur.layer_active) change = CHG_ON;
				end
				CMD_FORCE_OFF: begin
					nxt.activity_time = '0;
					nxt.held_keys     = '0;
					nxt.layer_active  = 1'b0;
					if (cur.layer_active) change = CHG_OFF;
				end
				default: begin
					nxt = cur;
				end
			endcase
		end
	end

	assign res.layer_engaged = nxt.layer_active;
	assign res.layer_change  = change;
	assign res.zero_report   = erase;

endmodule

>>> rtl/core/pointer_activity_layer_switch_unit.sv
// Pointer activity layer switch: top level with register port and beat pipeline.
// A beat is registered in stage 1, its result in stage 2; the state updates in one pass.
// Throughput: one beat per cycle; the input stalls only while both stages are full
// and the result is stalled.
// Reset (arst_n low, async): layer off, times and key count zero, registers at defaults.
// Depends on palsw_pkg, palsw_next and the assertion macro header.
module pointer_activity_layer_switch_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [palsw_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	input  logic                          item_valid,
	output logic                          item_stall,
	input  logic [1:0]                    command,
	input  logic [15:0]                   now_ms,
	input  logic                          key_is_event,
	input  logic                          key_pressed,
	input  logic [1:0]                    key_kind,
	input  logic [4:0]                    key_target_layer,
	input  logic signed [7:0]             move_x,
	input  logic signed [7:0]             move_y,
	input  logic signed [7:0]             scroll_h,
	input  logic signed [7:0]             scroll_v,
	input  logic [7:0]                    buttons,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          layer_engaged,
	output logic [1:0]                    layer_change,
	output logic                          zero_report
);
	import palsw_pkg::*;

	`include "pointer_activity_layer_switch_unit_assert.svh"

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	result_t res_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	logic    valid_s2;
	logic    adv_s2;
	logic    cfg_wr;
	logic [2:0] reg_idx;

	// ---------------- register port ----------------
	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable            <= 1'b0;
			cfg_q.ptr_layer         <= '0;
			cfg_q.idle_timeout      <= RST_IDLE_TMO;
			cfg_q.key_guard         <= RST_KEY_DELAY;
			cfg_q.hold_debounce     <= RST_DEBOUNCE;
			cfg_q.motion_threshold  <= RST_MOTION_THR;
			cfg_q.suppress_in_delay <= 1'b0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_ENABLE:     cfg_q.enable            <= pwdata[0];
				REG_LAYER:      cfg_q.ptr_layer         <= pwdata[4:0];
				REG_IDLE_TMO:   cfg_q.idle_timeout      <= pwdata[15:0];
				REG_KEY_DELAY:  cfg_q.key_guard         <= pwdata[15:0];
				REG_DEBOUNCE:   cfg_q.hold_debounce     <= pwdata[7:0];
				REG_MOTION_THR: cfg_q.motion_threshold  <= pwdata[7:0];
				REG_SUPPRESS:   cfg_q.suppress_in_delay <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_ENABLE:     prdata = {31'd0, cfg_q.enable};
			REG_LAYER:      prdata = {27'd0, cfg_q.ptr_layer};
			REG_IDLE_TMO:   prdata = {16'd0, cfg_q.idle_timeout};
			REG_KEY_DELAY:  prdata = {16'd0, cfg_q.key_guard};
			REG_DEBOUNCE:   prdata = {24'd0, cfg_q.hold_debounce};
			REG_MOTION_THR: prdata = {24'd0, cfg_q.motion_threshold};
			REG_SUPPRESS:   prdata = {31'd0, cfg_q.suppress_in_delay};
			default:        prdata = 32'd0;
		endcase
	end

	// ---------------- beat pipeline ----------------
	assign adv_s2     = !valid_s2 || !result_stall;
	assign item_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1.command          <= cmd_t'(command);
			item_s1.now_ms           <= now_ms;
			item_s1.key_is_event     <= key_is_event;
			item_s1.key_pressed      <= key_pressed;
			item_s1.key_kind         <= key_kind;
			item_s1.key_target_layer <= key_target_layer;
			item_s1.move_x           <= move_x;
			item_s1.move_y           <= move_y;
			item_s1.scroll_h         <= scroll_h;
			item_s1.scroll_v         <= scroll_v;
			item_s1.buttons          <= buttons;
		end
	end

	palsw_next u_next (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// state commits in the same edge that loads the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
			if (valid_s1) state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) res_s2 <= res_nxt;
	end

	assign result_valid  = valid_s2;
	assign layer_engaged = res_s2.layer_engaged;
	assign layer_change  = res_s2.layer_change;
	assign zero_report   = res_s2.zero_report;

	// ---------------- checks ----------------
	`PALSW_ASSERT(a_held_only_on, !state_q.layer_active |-> (state_q.held_keys == 8'd0),
		"keys counted while layer off")
	`PALSW_ASSERT(a_change_on,
		(result_valid && (res_s2.layer_change == CHG_ON)) |-> res_s2.layer_engaged,
		"turn-on reported with layer off")
	`PALSW_ASSERT(a_change_off,
		(result_valid && (res_s2.layer_change == CHG_OFF)) |-> !res_s2.layer_engaged,
		"turn-off reported with layer on")
	`PALSW_ASSERT_NEXT(a_result_tracks_state, valid_s1 && adv_s2,
		result_valid && (res_s2.layer_engaged == state_q.layer_active), "result and state disagree")
	`PALSW_ASSERT(a_stall_needs_beat, item_stall |-> (valid_s1 && valid_s2 && result_stall),
		"input stalled with room")

endmodule
